>>> sv/iafp_pkg.sv
package iafp_pkg;

    localparam int unsigned POS_W = 4;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_GYRO  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // position 0 is header hunt, position 10 carries the checksum
    localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE     = 4'd1;
    localparam logic [POS_W-1:0] POS_X_LO     = 4'd2;
    localparam logic [POS_W-1:0] POS_X_HI     = 4'd3;
    localparam logic [POS_W-1:0] POS_Y_LO     = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI     = 4'd5;
    localparam logic [POS_W-1:0] POS_Z_LO     = 4'd6;
    localparam logic [POS_W-1:0] POS_Z_HI     = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 4'd10;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic               checksum_ok;
        logic               angle_fresh;
    } result_t;

endpackage

>>> sv/iafp_collect.sv
module iafp_collect (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    output logic                  frame_done,
    output iafp_pkg::result_t     result
);

    logic [iafp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [7:0]                 type_reg, type_next;
    logic [47:0]                payload_reg, payload_next;
    logic [1:0]                 kind;
    logic                       sum_match;

    always_comb begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        payload_next = payload_reg;
        frame_done   = 1'b0;
        if (accept) begin
            if (pos_reg == iafp_pkg::POS_HUNT) begin
                if (rx_byte == iafp_pkg::HDR_BYTE) begin
                    sum_next = iafp_pkg::HDR_BYTE;
                    pos_next = iafp_pkg::POS_TYPE;
                end
            end else if (pos_reg < iafp_pkg::POS_CHECKSUM) begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + 4'd1;
                case (pos_reg)
                    iafp_pkg::POS_TYPE: type_next            = rx_byte;
                    iafp_pkg::POS_X_LO: payload_next[7:0]    = rx_byte;
                    iafp_pkg::POS_X_HI: payload_next[15:8]   = rx_byte;
                    iafp_pkg::POS_Y_LO: payload_next[23:16]  = rx_byte;
                    iafp_pkg::POS_Y_HI: payload_next[31:24]  = rx_byte;
                    iafp_pkg::POS_Z_LO: payload_next[39:32]  = rx_byte;
                    iafp_pkg::POS_Z_HI: payload_next[47:40]  = rx_byte;
                    default: ;
                endcase
            end else begin
                // checksum byte, or an unreachable position past it
                frame_done = 1'b1;
                pos_next   = iafp_pkg::POS_HUNT;
                sum_next   = 8'd0;
            end
        end
    end

    always_comb begin
        case (type_reg)
            iafp_pkg::TYPE_ACCEL: kind = iafp_pkg::KIND_ACCEL;
            iafp_pkg::TYPE_GYRO:  kind = iafp_pkg::KIND_GYRO;
            iafp_pkg::TYPE_ANGLE: kind = iafp_pkg::KIND_ANGLE;
            default:              kind = iafp_pkg::KIND_OTHER;
        endcase
        sum_match          = (sum_reg == rx_byte);
        result.frame_kind  = kind;
        result.axis_x      = payload_reg[15:0];
        result.axis_y      = payload_reg[31:16];
        result.axis_z      = payload_reg[47:32];
        result.checksum_ok = sum_match;
        result.angle_fresh = sum_match && (kind == iafp_pkg::KIND_ANGLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= iafp_pkg::POS_HUNT;
            sum_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        type_reg    <= type_next;
        payload_reg <= payload_next;
    end

endmodule

>>> sv/iafp_out_reg.sv
module iafp_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  iafp_pkg::result_t     load_data,
    input  logic                  m_ready,
    output logic                  m_valid,
    output iafp_pkg::result_t     m_data,
    output logic                  can_load
);

    logic              valid_reg, valid_next;
    iafp_pkg::result_t data_reg;

    // slot frees up in the same cycle its transaction completes
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

>>> sv/imu_angle_frame_parser_top.sv
// Parser for 11-byte sensor frames arriving one serial byte per transaction. The
// block hunts for the 0x55 header, stores the type byte and six payload bytes,
// keeps an 8-bit running sum of bytes 0..9 and, on the checksum byte, returns
// one result: frame kind, three signed little-endian axis values, a checksum
// flag and an angle-fresh flag. Bytes outside a frame produce no result. One byte
// is accepted every clock cycle with s_ready high; the result appears on the m_
// side the cycle after its checksum byte is accepted, held in a single output
// register. s_ready drops only while that register holds a result the consumer
// has not taken, so a stalled consumer stops the byte stream after at most one
// result. A 0x55 inside a frame is ordinary data; the parser does not resynchronize.
module imu_angle_frame_parser_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_kind,
    output logic signed [15:0] m_axis_x,
    output logic signed [15:0] m_axis_y,
    output logic signed [15:0] m_axis_z,
    output logic               m_checksum_ok,
    output logic               m_angle_fresh
);

    logic              accept;       // input transaction this cycle
    logic              frame_done;   // checksum byte accepted this cycle
    logic              can_load;     // output register free or draining
    iafp_pkg::result_t result;       // result of the frame being closed
    iafp_pkg::result_t out_data;

    assign s_ready = can_load;
    assign accept  = s_valid && s_ready;

    // frame position, running sum and captured fields
    iafp_collect u_collect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_rx_byte),
        .frame_done (frame_done),
        .result     (result)
    );

    // result register toward the consumer
    iafp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (frame_done),
        .load_data (result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data),
        .can_load  (can_load)
    );

    assign m_frame_kind  = out_data.frame_kind;
    assign m_axis_x      = out_data.axis_x;
    assign m_axis_y      = out_data.axis_y;
    assign m_axis_z      = out_data.axis_z;
    assign m_checksum_ok = out_data.checksum_ok;
    assign m_angle_fresh = out_data.angle_fresh;

endmodule

>>> sv/iafp_checker.sv
module iafp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_frame_kind,
    input logic               m_checksum_ok,
    input logic               m_angle_fresh
);

    // a held result must not be lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // angle-fresh only on a good angle frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_angle_fresh |-> m_checksum_ok && m_frame_kind == iafp_pkg::KIND_ANGLE)
        else $error("angle_fresh without good angle frame");

    // full output register back-pressures the byte stream
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind imu_angle_frame_parser_top iafp_checker u_iafp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_frame_kind  (m_frame_kind),
    .m_checksum_ok (m_checksum_ok),
    .m_angle_fresh (m_angle_fresh)
);
